>>> hdl/stq_pkg.sv
// shared constants and types for the sorted timer queue
// no dependencies
package stq_pkg;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned AW          = $clog2(CAPACITY);
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1);
  localparam int unsigned NUM_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_ADJUST = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;
  localparam logic [1:0] REQ_TICK   = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_DUP     = 3'd3;
  localparam logic [2:0] ST_EXPIRED = 3'd4;
  localparam logic [2:0] ST_NONE    = 3'd5;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] expiry;
  } stq_entry_t;

endpackage

>>> hdl/stq_if.sv
// request and result channel interfaces of the sorted timer queue
// no dependencies
interface stq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] timer_id;
  logic [31:0] expire_time;
  logic [31:0] now_time;
  modport source (output valid, req_type, timer_id, expire_time, now_time, input ready);
  modport sink   (input valid, req_type, timer_id, expire_time, now_time, output ready);
endinterface

interface stq_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] expired_id;
  logic        last_result;
  modport source (output valid, status, expired_id, last_result, input ready);
  modport sink   (input valid, status, expired_id, last_result, output ready);
endinterface

>>> hdl/sorted_timer_queue.sv
// sorted timer queue: one request at a time over the entry ram, scanned one entry at a time
// add/delete: a full scan, then a shift of the entries behind the position; refused requests skip it
// adjust removes the entry, rescans the shortened list and reinserts it at its new place
// tick: each expired head is removed by a left shift, up to 16 entries; ready returns in the cycle after
// the final result loads, and the next request is taken while it still waits in the output register
// reset (async, active low) empties the queue; the ram needs no clearing pass.
module sorted_timer_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  stq_req_if.sink    req,
  stq_res_if.source  res
);
  import stq_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SC_RD  = 4'd1;
  localparam logic [3:0] S_SC_CHK = 4'd2;
  localparam logic [3:0] S_DEC    = 4'd3;
  localparam logic [3:0] S_SHL_RD = 4'd4;
  localparam logic [3:0] S_SHL_WR = 4'd5;
  localparam logic [3:0] S_SHR_RD = 4'd6;
  localparam logic [3:0] S_SHR_WR = 4'd7;
  localparam logic [3:0] S_TK_RD  = 4'd8;
  localparam logic [3:0] S_TK_CHK = 4'd9;
  localparam logic [3:0] S_SEND   = 4'd10;

  logic [3:0]       state_q, state_d;
  logic [1:0]       op_q, op_d;
  logic [15:0]      id_q, id_d;
  logic [31:0]      exp_q, exp_d, now_q, now_d;
  logic [CNT_W-1:0] count_q, count_d, idx_q, idx_d, fpos_q, fpos_d, ipos_q, ipos_d;
  logic             fnd_q, fnd_d, ins_q, ins_d, phase_q, phase_d;
  logic [NUM_W-1:0] n_q, n_d;
  logic             pend_v_q, pend_v_d;
  logic [15:0]      pend_id_q, pend_id_d;
  logic [2:0]       rst_st_q, rst_st_d;
  logic [15:0]      rid_q, rid_d;
  logic             rlast_q, rlast_d;
  logic             ov_q, ov_d, olast_q, olast_d;
  logic [2:0]       ost_q, ost_d;
  logic [15:0]      oid_q, oid_d;

  logic             rd_en, wr_en, out_free, out_load;
  logic [AW-1:0]    rd_addr, wr_addr;
  stq_entry_t       rd_data, wr_data;
  logic [CNT_W-1:0] ins_pos;

  stq_ram #(.DEPTH(CAPACITY), .WIDTH($bits(stq_entry_t))) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign out_free  = !ov_q || res.ready;
  assign ins_pos   = ins_q ? ipos_q : count_q;
  assign req.ready = (state_q == S_IDLE);

  assign res.valid       = ov_q;
  assign res.status      = ost_q;
  assign res.expired_id  = oid_q;
  assign res.last_result = olast_q;

  always_comb begin
    state_d = state_q; op_d = op_q; id_d = id_q; exp_d = exp_q; now_d = now_q;
    count_d = count_q; idx_d = idx_q; fpos_d = fpos_q; ipos_d = ipos_q;
    fnd_d = fnd_q; ins_d = ins_q; phase_d = phase_q; n_d = n_q;
    pend_v_d = pend_v_q; pend_id_d = pend_id_q;
    rst_st_d = rst_st_q; rid_d = rid_q; rlast_d = rlast_q;
    out_load = 1'b0; ost_d = ost_q; oid_d = oid_q; olast_d = olast_q;
    rd_en = 1'b0; rd_addr = idx_q[AW-1:0];
    wr_en = 1'b0; wr_addr = idx_q[AW-1:0]; wr_data = rd_data;

    case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          op_d = req.req_type; id_d = req.timer_id;
          exp_d = req.expire_time; now_d = req.now_time;
          idx_d = '0; fnd_d = 1'b0; ins_d = 1'b0; phase_d = 1'b0;
          n_d = '0; pend_v_d = 1'b0;
          state_d = (req.req_type == REQ_TICK) ? S_TK_RD : S_SC_RD;
        end
      end
      S_SC_RD: begin
        if (idx_q == count_q) begin
          state_d = S_DEC;
        end else begin
          rd_en = 1'b1;
          state_d = S_SC_CHK;
        end
      end
      S_SC_CHK: begin
        if (!fnd_q && rd_data.id == id_q) begin
          fnd_d = 1'b1; fpos_d = idx_q;
        end
        // insertion point: first entry strictly later than the new expiry
        if (!ins_q && rd_data.expiry > exp_q) begin
          ins_d = 1'b1; ipos_d = idx_q;
        end
        idx_d = idx_q + CNT_W'(1);
        state_d = S_SC_RD;
      end
      S_DEC: begin
        rid_d = '0; rlast_d = 1'b1;
        case (op_q)
          REQ_ADD: begin
            if (fnd_q) begin
              rst_st_d = ST_DUP; state_d = S_SEND;
            end else if (count_q == CNT_W'(CAPACITY)) begin
              rst_st_d = ST_FULL; state_d = S_SEND;
            end else begin
              idx_d = count_q; ipos_d = ins_pos; state_d = S_SHR_RD;
            end
          end
          REQ_ADJUST: begin
            if (phase_q) begin
              idx_d = count_q; ipos_d = ins_pos; state_d = S_SHR_RD;
            end else if (!fnd_q) begin
              rst_st_d = ST_UNKNOWN; state_d = S_SEND;
            end else begin
              idx_d = fpos_q; state_d = S_SHL_RD;
            end
          end
          default: begin
            if (!fnd_q) begin
              rst_st_d = ST_UNKNOWN; state_d = S_SEND;
            end else begin
              idx_d = fpos_q; state_d = S_SHL_RD;
            end
          end
        endcase
      end
      S_SHL_RD: begin
        if (idx_q + CNT_W'(1) >= count_q) begin
          count_d = count_q - CNT_W'(1);
          case (op_q)
            REQ_DELETE: begin
              rst_st_d = ST_OK; rid_d = '0; rlast_d = 1'b1; state_d = S_SEND;
            end
            REQ_ADJUST: begin
              // second pass finds the new place in the shortened list
              idx_d = '0; fnd_d = 1'b0; ins_d = 1'b0; phase_d = 1'b1;
              state_d = S_SC_RD;
            end
            default: state_d = S_TK_RD;
          endcase
        end else begin
          rd_en = 1'b1;
          rd_addr = idx_q[AW-1:0] + AW'(1);
          state_d = S_SHL_WR;
        end
      end
      S_SHL_WR: begin
        wr_en = 1'b1;
        idx_d = idx_q + CNT_W'(1);
        state_d = S_SHL_RD;
      end
      S_SHR_RD: begin
        if (idx_q == ipos_q) begin
          wr_en = 1'b1;
          wr_data.id = id_q; wr_data.expiry = exp_q;
          count_d = count_q + CNT_W'(1);
          rst_st_d = ST_OK; rid_d = '0; rlast_d = 1'b1;
          state_d = S_SEND;
        end else begin
          rd_en = 1'b1;
          rd_addr = idx_q[AW-1:0] - AW'(1);
          state_d = S_SHR_WR;
        end
      end
      S_SHR_WR: begin
        wr_en = 1'b1;
        idx_d = idx_q - CNT_W'(1);
        state_d = S_SHR_RD;
      end
      S_TK_RD: begin
        if (count_q == '0 || n_q == NUM_W'(MAX_RESULTS)) begin
          rst_st_d = pend_v_q ? ST_EXPIRED : ST_NONE;
          rid_d = pend_v_q ? pend_id_q : '0;
          rlast_d = 1'b1;
          state_d = S_SEND;
        end else begin
          rd_en = 1'b1;
          rd_addr = '0;
          state_d = S_TK_CHK;
        end
      end
      S_TK_CHK: begin
        if (rd_data.expiry <= now_q) begin
          // the held id goes out only once the next head is known to expire too
          if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              out_load = 1'b1;
              ost_d = ST_EXPIRED; oid_d = pend_id_q; olast_d = 1'b0;
            end
            pend_v_d = 1'b1; pend_id_d = rd_data.id;
            n_d = n_q + NUM_W'(1);
            idx_d = '0;
            state_d = S_SHL_RD;
          end
        end else begin
          rst_st_d = pend_v_q ? ST_EXPIRED : ST_NONE;
          rid_d = pend_v_q ? pend_id_q : '0;
          rlast_d = 1'b1;
          state_d = S_SEND;
        end
      end
      S_SEND: begin
        if (out_free) begin
          out_load = 1'b1;
          ost_d = rst_st_q; oid_d = rid_q; olast_d = rlast_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (out_load) begin
      ov_d = 1'b1;
    end else if (res.ready) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ov_q     <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ov_q     <= ov_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; id_q <= id_d; exp_q <= exp_d; now_q <= now_d;
    idx_q <= idx_d; fpos_q <= fpos_d; ipos_q <= ipos_d;
    fnd_q <= fnd_d; ins_q <= ins_d; phase_q <= phase_d; n_q <= n_d;
    pend_id_q <= pend_id_d;
    rst_st_q <= rst_st_d; rid_q <= rid_d; rlast_q <= rlast_d;
    ost_q <= ost_d; oid_q <= oid_d; olast_q <= olast_d;
  end
endmodule

>>> hdl/stq_ram.sv
// generic single-write, single-read synchronous ram, registered read data
// no dependencies
module stq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 48
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end
endmodule

>>> hdl/stq_checker.sv
// port-level assertions for the sorted timer queue, bound to the top level
// depends on stq_pkg
module stq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  res_status,
  input logic [15:0] res_expired_id,
  input logic        res_last_result
);
  import stq_pkg::*;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_status) &&
      $stable(res_expired_id) && $stable(res_last_result))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_not_last_expired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_last_result |-> res_status == ST_EXPIRED)
    else $error("non-final result that is not an expiry");

  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_status != ST_EXPIRED |-> res_expired_id == '0 && res_last_result)
    else $error("status result with id or without last mark");
endmodule

bind sorted_timer_queue stq_checker u_stq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .res_status      (res.status),
  .res_expired_id  (res.expired_id),
  .res_last_result (res.last_result)
);
